>>> rtl/s2a_pkg.sv
// package with shared constants and controller/datapath interface types
package s2a_pkg;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 6;
  localparam int unsigned NUM_DIGITS  = 10;
  localparam int unsigned BCD_W       = 4 * NUM_DIGITS;
  localparam int unsigned DIGIT_IDX_W = 4;
  localparam int unsigned SHIFT_CNT_W = 5;

  localparam logic [CHAR_W-1:0]      ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0]      ASCII_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0]      ASCII_MINUS = 6'd45;
  localparam logic [SHIFT_CNT_W-1:0] LAST_SHIFT  = 5'd31;

  typedef struct packed {
    logic load;
    logic shift;
    logic lead;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic ptr_zero;
  } sts_t;

endpackage

>>> rtl/signed_int_to_decimal_ascii.sv
// top level: signed 32-bit integer to decimal ascii text, one character per strobe
// a minus sign is strobed for a negative value once the conversion is done, then the digits, one per cycle
// a new request is accepted only when idle, after the last digit of the previous one has been emitted
// the 32 shift-add-3 steps of the bcd converter come before the first character
// characters are strobed for one cycle each; the receiver cannot stall them
// asynchronous active-low reset returns the controller to idle and clears the strobe
module signed_int_to_decimal_ascii (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [s2a_pkg::VALUE_W-1:0]  value_i,
  output logic                                strobe_o,
  output logic [s2a_pkg::CHAR_W-1:0]          character_o,
  output logic                                last_char_o
);
  import s2a_pkg::*;

  cmd_t cmd;
  sts_t sts;

  s2a_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  s2a_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

endmodule

>>> rtl/s2a_dp.sv
// datapath: magnitude, shift-add-3 bcd conversion and character output
module s2a_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  s2a_pkg::cmd_t                       cmd_i,
  output s2a_pkg::sts_t                       sts_o,
  input  logic signed [s2a_pkg::VALUE_W-1:0]  value_i,
  output logic                                strobe_o,
  output logic [s2a_pkg::CHAR_W-1:0]          character_o,
  output logic                                last_char_o
);
  import s2a_pkg::*;

  logic [VALUE_W-1:0]     mag_q, mag_d;
  logic [BCD_W-1:0]       bcd_q, bcd_d;
  logic [BCD_W-1:0]       bcd_adj;
  logic                   neg_q, neg_d;
  logic [DIGIT_IDX_W-1:0] ptr_q, ptr_d;
  logic [DIGIT_IDX_W-1:0] lead_idx;
  logic [3:0]             cur_digit;
  logic                   strobe_q, strobe_d;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   last_q, last_d;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // most significant non-zero digit, zero when all digits are zero
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] != 4'd0) begin
        lead_idx = DIGIT_IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd_q[{ptr_q, 2'b00} +: 4];

  always_comb begin
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    neg_d    = neg_q;
    ptr_d    = ptr_q;
    strobe_d = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    if (cmd_i.load) begin
      neg_d = value_i[VALUE_W-1];
      mag_d = value_i[VALUE_W-1] ? (~value_i + VALUE_W'(1)) : value_i;
      bcd_d = '0;
    end
    if (cmd_i.shift) begin
      {bcd_d, mag_d} = {bcd_adj[BCD_W-2:0], mag_q, 1'b0};
    end
    if (cmd_i.lead) begin
      ptr_d = lead_idx;
    end
    if (cmd_i.emit_sign) begin
      strobe_d = 1'b1;
      char_d   = ASCII_MINUS;
      last_d   = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      strobe_d = 1'b1;
      char_d   = ASCII_ZERO + CHAR_W'(cur_digit);
      last_d   = (ptr_q == '0);
      ptr_d    = ptr_q - DIGIT_IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    neg_q  <= neg_d;
    ptr_q  <= ptr_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign sts_o.neg      = neg_q;
  assign sts_o.ptr_zero = (ptr_q == '0);

  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule

>>> rtl/s2a_ctrl.sv
// controller: sequences load, conversion shifts and character emission
module s2a_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  s2a_pkg::sts_t sts_i,
  output s2a_pkg::cmd_t cmd_o
);
  import s2a_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONV  = 2'd1;
  localparam logic [1:0] ST_LEAD  = 2'd2;
  localparam logic [1:0] ST_DIGIT = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [SHIFT_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        cnt_d       = cnt_q + SHIFT_CNT_W'(1);
        if (cnt_q == LAST_SHIFT) begin
          state_d = ST_LEAD;
        end
      end
      ST_LEAD: begin
        cmd_o.lead      = 1'b1;
        cmd_o.emit_sign = sts_i.neg;
        state_d         = ST_DIGIT;
      end
      ST_DIGIT: begin
        cmd_o.emit_digit = 1'b1;
        if (sts_i.ptr_zero) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> rtl/s2a_chk.sv
// port-level checker for the converter and its bind to the top level
module s2a_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                strobe_o,
  input logic [s2a_pkg::CHAR_W-1:0]          character_o,
  input logic                                last_char_o
);
  import s2a_pkg::*;

  logic is_digit;
  assign is_digit = (character_o >= ASCII_ZERO) && (character_o <= ASCII_NINE);

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (is_digit || (character_o == ASCII_MINUS && !last_char_o)))
    else $error("illegal character or minus sign marked last");

  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_minus_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && character_o == ASCII_MINUS) |=> (strobe_o && is_digit))
    else $error("minus sign not followed by a digit");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (strobe_o && last_char_o))
    else $error("busy dropped without final character");

  a_no_value_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_char_o) |=> strobe_o)
    else $error("text ended without a last character");

endmodule

bind signed_int_to_decimal_ascii s2a_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .strobe_o    (strobe_o),
  .character_o (character_o),
  .last_char_o (last_char_o)
);
